// ===== hw/rtl/i2c_master_bit_sequencer_defines.svh =====
// Assertion macros shared by the I2C master bit sequencer RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// Property that holds in the same cycle.
`define I2CMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent holds in the cycle after the antecedent.
`define I2CMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/i2cms_pkg.sv =====
// Types, codes and phase tables of the I2C master bit sequencer.
// Used by every RTL module of the block; depends on nothing.
package i2cms_pkg;

  typedef enum logic [2:0] {
    OpStart   = 3'd0,
    OpStop    = 3'd1,
    OpSend    = 3'd2,
    OpRead    = 3'd3,
    OpWaitAck = 3'd4,
    OpAck     = 3'd5,
    OpNack    = 3'd6,
    OpProbe   = 3'd7
  } op_e;

  typedef enum logic [4:0] {
    PhIdle  = 5'd0,
    PhStA   = 5'd1,
    PhStB   = 5'd2,
    PhStC   = 5'd3,
    PhStEnd = 5'd4,
    PhTxA   = 5'd5,
    PhTxB   = 5'd6,
    PhTxC   = 5'd7,
    PhTxD   = 5'd8,
    PhRxA   = 5'd9,
    PhRxB   = 5'd10,
    PhRxC   = 5'd11,
    PhWaA   = 5'd12,
    PhWaB   = 5'd13,
    PhWaC   = 5'd14,
    PhWaD   = 5'd15,
    PhSpA   = 5'd16,
    PhSpB   = 5'd17,
    PhAkA   = 5'd18,
    PhAkB   = 5'd19,
    PhAkC   = 5'd20,
    PhAkD   = 5'd21
  } phase_e;

  localparam int unsigned DelayWidth = 12;
  localparam logic [DelayWidth-1:0] DelayReset = 12'd10;
  localparam logic [3:0] BitsPerByte = 4'd8;
  localparam logic [3:0] LastBit = 4'd7;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       sda_line;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_missing;
    logic       rejected;
  } out_item_t;

  function automatic phase_e first_phase(op_e op);
    phase_e ph;
    case (op)
      OpStart:   ph = PhStA;
      OpStop:    ph = PhSpA;
      OpSend:    ph = PhTxA;
      OpRead:    ph = PhRxA;
      OpWaitAck: ph = PhWaA;
      OpAck:     ph = PhAkA;
      OpNack:    ph = PhAkA;
      OpProbe:   ph = PhStA;
      default:   ph = PhIdle;
    endcase
    return ph;
  endfunction

  function automatic phase_e next_phase(phase_e ph);
    phase_e nx;
    case (ph)
      PhStA:   nx = PhStB;
      PhStB:   nx = PhStC;
      PhStC:   nx = PhStEnd;
      PhTxA:   nx = PhTxB;
      PhTxB:   nx = PhTxC;
      PhTxC:   nx = PhTxD;
      PhRxA:   nx = PhRxB;
      PhRxB:   nx = PhRxC;
      PhWaA:   nx = PhWaB;
      PhWaB:   nx = PhWaC;
      PhWaC:   nx = PhWaD;
      PhSpA:   nx = PhSpB;
      PhAkA:   nx = PhAkB;
      PhAkB:   nx = PhAkC;
      PhAkC:   nx = PhAkD;
      default: nx = PhIdle;
    endcase
    return nx;
  endfunction

endpackage

// ===== hw/rtl/i2c_master_bit_sequencer.sv =====
// Top level of the I2C master bit sequencer.
// Instantiates i2cms_in_stage, i2cms_core and i2cms_out_stage; uses i2cms_pkg.
//
// Each input transaction is one bus tick and gives exactly one result transaction.
// A tick enters the input register, the sequencer state is updated by one level of
// logic from there into the result register, and a new tick is taken every cycle
// while the output is not stalled, so the sustained rate is then one tick per clock.
// The delay register sets how many ticks each bus phase lasts; the user must write it
// through the configuration port only while idle, which the block does not enforce.
module i2c_master_bit_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [11:0]          cfg_data_i,
  output logic                 cfg_ready_o,
  input  logic                 in_valid_i,
  input  i2cms_pkg::in_item_t  in_item_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output i2cms_pkg::out_item_t out_item_o,
  input  logic                 out_stall_i
);

  logic                 in_full, out_room, run;
  i2cms_pkg::in_item_t  item;
  i2cms_pkg::out_item_t result;

  assign cfg_ready_o = 1'b1;
  assign run         = in_full && out_room;

  i2cms_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .take_i     (run),
    .full_o     (in_full),
    .item_o     (item)
  );

  i2cms_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .run_i       (run),
    .item_i      (item),
    .result_o    (result)
  );

  i2cms_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (run),
    .result_i    (result),
    .room_o      (out_room),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== hw/rtl/i2cms_in_stage.sv =====
// Input register of the I2C master bit sequencer.
// Holds one tick transaction until the core consumes it; uses i2cms_pkg.
module i2cms_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  i2cms_pkg::in_item_t in_item_i,
  output logic                in_stall_o,
  input  logic                take_i,
  output logic                full_o,
  output i2cms_pkg::in_item_t item_o
);

  logic                full_q, full_d;
  i2cms_pkg::in_item_t item_q;
  logic                load;

  assign in_stall_o = full_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    full_d = full_q;
    if (load) begin
      full_d = 1'b1;
    end else if (take_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign full_o = full_q;
  assign item_o = item_q;

endmodule

// ===== hw/rtl/i2cms_core.sv =====
// Bus sequencer state machine of the I2C master bit sequencer.
// Uses i2cms_pkg and the assertion macros of i2c_master_bit_sequencer_defines.svh.
`include "i2c_master_bit_sequencer_defines.svh"

module i2cms_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [11:0]           cfg_data_i,
  input  logic                  run_i,
  input  i2cms_pkg::in_item_t   item_i,
  output i2cms_pkg::out_item_t  result_o
);

  logic [11:0]       delay_q;
  i2cms_pkg::op_e    cur_op_q, cur_op_d;
  i2cms_pkg::phase_e phase_q, phase_d;
  logic [3:0]        bit_q, bit_d;
  logic [7:0]        shift_q, shift_d;
  logic [11:0]       wait_q, wait_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              ack_q, ack_d;
  logic              busy_q, busy_d;
  logic [7:0]        last_read_q, last_read_d;

  logic              start, fire, step, done, rejected;
  logic [11:0]       wait_dec;
  i2cms_pkg::op_e    op_eff;
  i2cms_pkg::phase_e exec_ph, res_ph;
  logic              finish, abort, clr_bit, latch_read;

  always_comb begin
    start    = run_i && !busy_q && item_i.cmd_valid;
    wait_dec = wait_q - 12'd1;
    fire     = run_i && busy_q && (wait_dec == 12'd0);
    step     = start || fire;
    op_eff   = start ? i2cms_pkg::op_e'(item_i.operation) : cur_op_q;
    exec_ph  = start ? i2cms_pkg::first_phase(op_eff) : phase_q;
    res_ph     = exec_ph;
    finish     = 1'b0;
    abort      = 1'b0;
    clr_bit    = 1'b0;
    latch_read = 1'b0;
    case (exec_ph)
      i2cms_pkg::PhStEnd: begin
        if (op_eff == i2cms_pkg::OpProbe) begin
          res_ph  = i2cms_pkg::PhTxA;
          clr_bit = 1'b1;
        end else begin
          finish = 1'b1;
        end
      end
      i2cms_pkg::PhTxD: begin
        if (bit_q < i2cms_pkg::BitsPerByte) begin
          res_ph = i2cms_pkg::PhTxA;
        end else if (op_eff == i2cms_pkg::OpProbe) begin
          res_ph = i2cms_pkg::PhWaA;
        end else begin
          finish = 1'b1;
        end
      end
      i2cms_pkg::PhRxC: begin
        if (bit_q < i2cms_pkg::BitsPerByte) begin
          res_ph = i2cms_pkg::PhRxA;
        end else begin
          latch_read = 1'b1;
          finish     = 1'b1;
        end
      end
      i2cms_pkg::PhWaD: begin
        if (op_eff == i2cms_pkg::OpProbe) begin
          res_ph = i2cms_pkg::PhSpA;
        end else begin
          finish = 1'b1;
        end
      end
      i2cms_pkg::PhSpB, i2cms_pkg::PhAkD: begin
        finish = 1'b1;
      end
      default: begin
        if (!(exec_ph inside {i2cms_pkg::PhStA, i2cms_pkg::PhStB, i2cms_pkg::PhStC,
                              i2cms_pkg::PhTxA, i2cms_pkg::PhTxB, i2cms_pkg::PhTxC,
                              i2cms_pkg::PhRxA, i2cms_pkg::PhRxB, i2cms_pkg::PhWaA,
                              i2cms_pkg::PhWaB, i2cms_pkg::PhWaC, i2cms_pkg::PhSpA,
                              i2cms_pkg::PhAkA, i2cms_pkg::PhAkB, i2cms_pkg::PhAkC})) begin
          abort = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    busy_d   = busy_q;
    wait_d   = wait_q;
    cur_op_d = cur_op_q;
    done     = 1'b0;
    if (run_i && busy_q) begin
      wait_d = wait_dec;
    end
    if (start) begin
      cur_op_d = op_eff;
    end
    if (step) begin
      if (finish) begin
        phase_d = i2cms_pkg::PhIdle;
        busy_d  = 1'b0;
        done    = 1'b1;
      end else if (abort) begin
        phase_d = i2cms_pkg::PhIdle;
        busy_d  = 1'b0;
      end else begin
        phase_d = i2cms_pkg::next_phase(res_ph);
        busy_d  = 1'b1;
        wait_d  = (delay_q == 12'd0) ? 12'd1 : delay_q;
      end
    end
  end

  always_comb begin
    shift_d     = start ? item_i.write_data : shift_q;
    bit_d       = (start || (step && clr_bit)) ? 4'd0 : bit_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    ack_d       = ack_q;
    last_read_d = last_read_q;
    rejected    = run_i && busy_q && item_i.cmd_valid;
    if (step) begin
      if (latch_read) begin
        last_read_d = shift_q;
      end
      if (exec_ph == i2cms_pkg::PhSpB) begin
        sda_d = 1'b1;
      end
      if (exec_ph == i2cms_pkg::PhAkD && op_eff == i2cms_pkg::OpAck) begin
        sda_d = 1'b1;
      end
      if (!finish && !abort) begin
        case (res_ph)
          i2cms_pkg::PhStA: begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end
          i2cms_pkg::PhStB: sda_d = 1'b0;
          i2cms_pkg::PhStC: scl_d = 1'b0;
          i2cms_pkg::PhTxA: sda_d = shift_d[7];
          i2cms_pkg::PhTxB: scl_d = 1'b1;
          i2cms_pkg::PhTxC: begin
            scl_d = 1'b0;
            if (bit_d == i2cms_pkg::LastBit) begin
              sda_d = 1'b1;
            end
            shift_d = {shift_d[6:0], 1'b0};
            bit_d   = bit_d + 4'd1;
          end
          i2cms_pkg::PhRxA: begin
            shift_d = {shift_d[6:0], 1'b0};
            scl_d   = 1'b1;
          end
          i2cms_pkg::PhRxB: begin
            if (item_i.sda_line) begin
              shift_d[0] = 1'b1;
            end
            scl_d = 1'b0;
            bit_d = bit_d + 4'd1;
          end
          i2cms_pkg::PhWaA: sda_d = 1'b1;
          i2cms_pkg::PhWaB: scl_d = 1'b1;
          i2cms_pkg::PhWaC: begin
            ack_d = item_i.sda_line;
            scl_d = 1'b0;
          end
          i2cms_pkg::PhSpA: begin
            sda_d = 1'b0;
            scl_d = 1'b1;
          end
          i2cms_pkg::PhAkA: sda_d = (op_eff == i2cms_pkg::OpNack);
          i2cms_pkg::PhAkB: scl_d = 1'b1;
          i2cms_pkg::PhAkC: scl_d = 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= i2cms_pkg::DelayReset;
      cur_op_q    <= i2cms_pkg::OpStart;
      phase_q     <= i2cms_pkg::PhIdle;
      bit_q       <= 4'd0;
      shift_q     <= 8'd0;
      wait_q      <= 12'd0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_q       <= 1'b0;
      busy_q      <= 1'b0;
      last_read_q <= 8'd0;
    end else begin
      if (cfg_valid_i) begin
        delay_q <= cfg_data_i;
      end
      cur_op_q    <= cur_op_d;
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      wait_q      <= wait_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      ack_q       <= ack_d;
      busy_q      <= busy_d;
      last_read_q <= last_read_d;
    end
  end

  always_comb begin
    result_o.scl_level   = scl_d;
    result_o.sda_level   = sda_d;
    result_o.busy_res    = busy_d;
    result_o.done_res    = done;
    result_o.read_byte   = last_read_d;
    result_o.ack_missing = ack_d;
    result_o.rejected    = rejected;
  end

  `I2CMS_ASSERT(idle_phase_when_free, !busy_q -> (phase_q == i2cms_pkg::PhIdle), "Free with phase set")
  `I2CMS_ASSERT(wait_nonzero_when_busy, busy_q -> (wait_q != 12'd0), "Busy with empty delay count")
  `I2CMS_ASSERT(done_clears_busy, done -> !busy_d, "Sequence done but still busy")
  `I2CMS_ASSERT_NEXT(cmd_starts_sequence, start, busy_q, "Accepted command did not start")

endmodule

// ===== hw/rtl/i2cms_out_stage.sv =====
// Result register of the I2C master bit sequencer.
// Holds one result transaction until the receiver takes it; uses i2cms_pkg.
module i2cms_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  i2cms_pkg::out_item_t result_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  output i2cms_pkg::out_item_t out_item_o,
  input  logic                 out_stall_i
);

  logic                 full_q, full_d;
  i2cms_pkg::out_item_t item_q;

  assign room_o = !full_q || !out_stall_i;

  always_comb begin
    full_d = full_q;
    if (load_i) begin
      full_d = 1'b1;
    end else if (!out_stall_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = full_q;
  assign out_item_o  = item_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the I2C master bit sequencer: drives bus ticks, predicts
// every result tick in a scoreboard class and compares them field by field.
// Depends on i2cms_pkg and the i2c_master_bit_sequencer RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned MaxPrinted = 25;

  class tick_scoreboard;
    logic [i2cms_pkg::DelayWidth-1:0] delay_q;
    i2cms_pkg::op_e                   op_q;
    i2cms_pkg::phase_e                ph_q;
    logic [3:0]                       bits_q;
    logic [7:0]                       shift_q;
    logic [i2cms_pkg::DelayWidth-1:0] wait_q;
    logic                             scl_q;
    logic                             sda_q;
    logic                             ack_q;
    logic                             busy_q;
    logic [7:0]                       read_q;
    i2cms_pkg::out_item_t             expected_levels[$];
    int unsigned                      errors;
    int unsigned                      n_ticks;
    int unsigned                      n_started;
    int unsigned                      n_finished;
    int unsigned                      n_dropped;
    int unsigned                      n_checked;

    function new();
      delay_q = i2cms_pkg::DelayReset;
      op_q = i2cms_pkg::OpStart;
      ph_q = i2cms_pkg::PhIdle;
      bits_q = '0;
      shift_q = '0;
      wait_q = '0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      ack_q = 1'b0;
      busy_q = 1'b0;
      read_q = '0;
      errors = 0;
      n_ticks = 0;
      n_started = 0;
      n_finished = 0;
      n_dropped = 0;
      n_checked = 0;
    endfunction

    // Runs pin changes until the next delay step starts; returns 1 when the command ends.
    function bit step_pins(logic sda_in);
      i2cms_pkg::phase_e nxt;
      bit                fin;
      bit                more;
      fin = 1'b0;
      more = 1'b1;
      while (more) begin
        more = 1'b0;
        nxt = i2cms_pkg::PhIdle;
        case (ph_q)
          i2cms_pkg::PhStA: begin
            sda_q = 1'b1;
            scl_q = 1'b1;
            nxt = i2cms_pkg::PhStB;
          end
          i2cms_pkg::PhStB: begin
            sda_q = 1'b0;
            nxt = i2cms_pkg::PhStC;
          end
          i2cms_pkg::PhStC: begin
            scl_q = 1'b0;
            nxt = i2cms_pkg::PhStEnd;
          end
          i2cms_pkg::PhStEnd: begin
            if (op_q == i2cms_pkg::OpProbe) begin
              bits_q = '0;
              ph_q = i2cms_pkg::PhTxA;
              more = 1'b1;
            end else begin
              ph_q = i2cms_pkg::PhIdle;
              fin = 1'b1;
            end
          end
          i2cms_pkg::PhTxA: begin
            sda_q = shift_q[7];
            nxt = i2cms_pkg::PhTxB;
          end
          i2cms_pkg::PhTxB: begin
            scl_q = 1'b1;
            nxt = i2cms_pkg::PhTxC;
          end
          i2cms_pkg::PhTxC: begin
            scl_q = 1'b0;
            if (bits_q == i2cms_pkg::LastBit) sda_q = 1'b1;
            shift_q = shift_q << 1;
            bits_q = bits_q + 4'd1;
            nxt = i2cms_pkg::PhTxD;
          end
          i2cms_pkg::PhTxD: begin
            if (bits_q < i2cms_pkg::BitsPerByte) begin
              ph_q = i2cms_pkg::PhTxA;
              more = 1'b1;
            end else if (op_q == i2cms_pkg::OpProbe) begin
              ph_q = i2cms_pkg::PhWaA;
              more = 1'b1;
            end else begin
              ph_q = i2cms_pkg::PhIdle;
              fin = 1'b1;
            end
          end
          i2cms_pkg::PhRxA: begin
            shift_q = shift_q << 1;
            scl_q = 1'b1;
            nxt = i2cms_pkg::PhRxB;
          end
          i2cms_pkg::PhRxB: begin
            if (sda_in) shift_q[0] = 1'b1;
            scl_q = 1'b0;
            bits_q = bits_q + 4'd1;
            nxt = i2cms_pkg::PhRxC;
          end
          i2cms_pkg::PhRxC: begin
            if (bits_q < i2cms_pkg::BitsPerByte) begin
              ph_q = i2cms_pkg::PhRxA;
              more = 1'b1;
            end else begin
              read_q = shift_q;
              ph_q = i2cms_pkg::PhIdle;
              fin = 1'b1;
            end
          end
          i2cms_pkg::PhWaA: begin
            sda_q = 1'b1;
            nxt = i2cms_pkg::PhWaB;
          end
          i2cms_pkg::PhWaB: begin
            scl_q = 1'b1;
            nxt = i2cms_pkg::PhWaC;
          end
          i2cms_pkg::PhWaC: begin
            ack_q = sda_in;
            scl_q = 1'b0;
            nxt = i2cms_pkg::PhWaD;
          end
          i2cms_pkg::PhWaD: begin
            if (op_q == i2cms_pkg::OpProbe) begin
              ph_q = i2cms_pkg::PhSpA;
              more = 1'b1;
            end else begin
              ph_q = i2cms_pkg::PhIdle;
              fin = 1'b1;
            end
          end
          i2cms_pkg::PhSpA: begin
            sda_q = 1'b0;
            scl_q = 1'b1;
            nxt = i2cms_pkg::PhSpB;
          end
          i2cms_pkg::PhSpB: begin
            sda_q = 1'b1;
            ph_q = i2cms_pkg::PhIdle;
            fin = 1'b1;
          end
          i2cms_pkg::PhAkA: begin
            sda_q = (op_q == i2cms_pkg::OpNack);
            nxt = i2cms_pkg::PhAkB;
          end
          i2cms_pkg::PhAkB: begin
            scl_q = 1'b1;
            nxt = i2cms_pkg::PhAkC;
          end
          i2cms_pkg::PhAkC: begin
            scl_q = 1'b0;
            nxt = i2cms_pkg::PhAkD;
          end
          i2cms_pkg::PhAkD: begin
            if (op_q == i2cms_pkg::OpAck) sda_q = 1'b1;
            ph_q = i2cms_pkg::PhIdle;
            fin = 1'b1;
          end
          default: begin
            ph_q = i2cms_pkg::PhIdle;
            busy_q = 1'b0;
          end
        endcase
        if (nxt != i2cms_pkg::PhIdle) begin
          ph_q = nxt;
          wait_q = (delay_q == '0) ? 12'd1 : delay_q;
        end
      end
      return fin;
    endfunction

    function void note_tick(i2cms_pkg::in_item_t t);
      i2cms_pkg::out_item_t e;
      bit                   dropped;
      bit                   fin;
      dropped = 1'b0;
      fin = 1'b0;
      n_ticks++;
      if (busy_q) begin
        dropped = t.cmd_valid;
        wait_q = wait_q - 12'd1;
        if (wait_q == '0) begin
          if (step_pins(t.sda_line)) fin = 1'b1;
        end
      end else if (t.cmd_valid) begin
        op_q = i2cms_pkg::op_e'(t.operation);
        shift_q = t.write_data;
        bits_q = '0;
        busy_q = 1'b1;
        n_started++;
        case (op_q)
          i2cms_pkg::OpStart, i2cms_pkg::OpProbe: ph_q = i2cms_pkg::PhStA;
          i2cms_pkg::OpStop:                      ph_q = i2cms_pkg::PhSpA;
          i2cms_pkg::OpSend:                      ph_q = i2cms_pkg::PhTxA;
          i2cms_pkg::OpRead:                      ph_q = i2cms_pkg::PhRxA;
          i2cms_pkg::OpWaitAck:                   ph_q = i2cms_pkg::PhWaA;
          default:                                ph_q = i2cms_pkg::PhAkA;
        endcase
        if (step_pins(t.sda_line)) fin = 1'b1;
      end
      if (fin) begin
        busy_q = 1'b0;
        n_finished++;
      end
      if (dropped) n_dropped++;
      e.scl_level = scl_q;
      e.sda_level = sda_q;
      e.busy_res = busy_q;
      e.done_res = fin;
      e.read_byte = read_q;
      e.ack_missing = ack_q;
      e.rejected = dropped;
      expected_levels.push_back(e);
    endfunction

    task report(string what, int got, int want);
      if (errors < MaxPrinted) begin
        $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
      end
      errors++;
    endtask

    task check_levels(i2cms_pkg::out_item_t got);
      i2cms_pkg::out_item_t w;
      if (expected_levels.size() == 0) begin
        report("result with nothing pending", 1, 0);
      end else begin
        w = expected_levels.pop_front();
        n_checked++;
        if (got.scl_level !== w.scl_level) report("scl_level", got.scl_level, w.scl_level);
        if (got.sda_level !== w.sda_level) report("sda_level", got.sda_level, w.sda_level);
        if (got.busy_res !== w.busy_res) report("busy_res", got.busy_res, w.busy_res);
        if (got.done_res !== w.done_res) report("done_res", got.done_res, w.done_res);
        if (got.read_byte !== w.read_byte) report("read_byte", got.read_byte, w.read_byte);
        if (got.ack_missing !== w.ack_missing) begin
          report("ack_missing", got.ack_missing, w.ack_missing);
        end
        if (got.rejected !== w.rejected) report("rejected", got.rejected, w.rejected);
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic [11:0]          cfg_data_i;
  logic                 cfg_ready_o;
  logic                 in_valid_i;
  i2cms_pkg::in_item_t  in_item_i;
  logic                 in_stall_o;
  logic                 out_valid_o;
  i2cms_pkg::out_item_t out_item_o;
  logic                 out_stall_i;

  tick_scoreboard sb = new();
  int unsigned    sender_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    hold_cycles;
  int unsigned    cycle_count;

  i2c_master_bit_sequencer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_levels(out_item_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic i2cms_pkg::in_item_t make_tick(logic v, logic [2:0] op,
                                                    logic [7:0] data, logic sda);
    i2cms_pkg::in_item_t t;
    t.cmd_valid = v;
    t.operation = op;
    t.write_data = data;
    t.sda_line = sda;
    return t;
  endfunction

  function automatic logic pick_sda(int mode);
    return (mode == 2) ? logic'($urandom_range(1)) : logic'(mode);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_tick(i2cms_pkg::in_item_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i = t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(t);
    @(negedge clk_i);
  endtask

  task automatic issue_command(i2cms_pkg::op_e op, logic [7:0] data, int sda_mode);
    send_tick(make_tick(1'b1, op, data, pick_sda(sda_mode)));
    while (sb.busy_q) begin
      send_tick(make_tick(1'b0, 3'($urandom), 8'($urandom), pick_sda(sda_mode)));
    end
  endtask

  task automatic free_sequencer(int unsigned noise_pct);
    while (sb.busy_q) begin
      send_tick(make_tick($urandom_range(99) < noise_pct, 3'($urandom_range(7)),
                          8'($urandom_range(255)), 1'($urandom_range(1))));
    end
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (sb.expected_levels.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_delay(logic [11:0] value);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.delay_q = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Mostly whole bus frames with random content, plus stray commands.
  task automatic run_traffic(int unsigned n);
    i2cms_pkg::op_e frame_ops[6] = '{i2cms_pkg::OpStart, i2cms_pkg::OpSend,
                                     i2cms_pkg::OpWaitAck, i2cms_pkg::OpRead,
                                     i2cms_pkg::OpNack, i2cms_pkg::OpStop};
    int unsigned    k;
    int unsigned    sent;
    logic [2:0]     op;
    k = 0;
    sent = 0;
    while (sent < n) begin
      if (sb.busy_q) begin
        send_tick(make_tick($urandom_range(99) < 4, 3'($urandom), 8'($urandom),
                            1'($urandom)));
      end else if ($urandom_range(99) < 70) begin
        if ($urandom_range(99) < 75) begin
          op = frame_ops[k % 6];
          k++;
        end else begin
          op = 3'($urandom_range(7));
        end
        send_tick(make_tick(1'b1, op, 8'($urandom), 1'($urandom)));
      end else begin
        send_tick(make_tick(1'b0, 3'($urandom), 8'($urandom), 1'($urandom)));
      end
      sent++;
    end
  endtask

  task automatic run_phase(logic [11:0] delay, int unsigned sidle, int unsigned rstall,
                           int unsigned hold, int unsigned n);
    write_delay(delay);
    sender_idle_pct = sidle;
    recv_stall_pct = rstall;
    @(posedge clk_i);
    hold_cycles = hold;
    @(negedge clk_i);
    run_traffic(n);
    free_sequencer(4);
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    cycle_count = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    issue_command(i2cms_pkg::OpStop, 8'h00, 2);
    settle();
    write_delay(12'd0);
    issue_command(i2cms_pkg::OpStart, 8'h00, 2);
    issue_command(i2cms_pkg::OpStop, 8'h00, 2);
    issue_command(i2cms_pkg::OpSend, 8'hFF, 2);
    issue_command(i2cms_pkg::OpSend, 8'h00, 2);
    issue_command(i2cms_pkg::OpSend, 8'hA5, 2);
    issue_command(i2cms_pkg::OpRead, 8'h00, 1);
    issue_command(i2cms_pkg::OpRead, 8'hFF, 0);
    issue_command(i2cms_pkg::OpRead, 8'h5A, 2);
    issue_command(i2cms_pkg::OpWaitAck, 8'h00, 0);
    issue_command(i2cms_pkg::OpWaitAck, 8'h00, 1);
    issue_command(i2cms_pkg::OpAck, 8'h00, 2);
    issue_command(i2cms_pkg::OpNack, 8'h00, 2);
    issue_command(i2cms_pkg::OpProbe, 8'h00, 0);
    issue_command(i2cms_pkg::OpProbe, 8'hFF, 1);
    send_tick(make_tick(1'b1, i2cms_pkg::OpSend, 8'h3C, 1'b0));
    send_tick(make_tick(1'b1, i2cms_pkg::OpRead, 8'hC3, 1'b1));
    free_sequencer(0);
    send_tick(make_tick(1'b1, i2cms_pkg::OpStop, 8'h00, 1'b1));
    send_tick(make_tick(1'b1, i2cms_pkg::OpStart, 8'hFF, 1'b0));
    free_sequencer(0);
    settle();

    run_phase(12'd1, 0, 0, 300, 220);
    run_phase(12'd2, 75, 0, 0, 180);
    run_phase(12'd3, 0, 75, 0, 180);
    run_phase(12'd1, 22, 22, 150, 180);

    write_delay(12'd100);
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    send_tick(make_tick(1'b1, i2cms_pkg::OpStop, 8'h81, 1'b0));
    free_sequencer(4);
    settle();

    run_phase(12'd5, 0, 0, 0, 100);

    if (sb.expected_levels.size() != 0) begin
      sb.report("results never seen", 0, sb.expected_levels.size());
    end
    $display("Ran %0d ticks and checked %0d results: %0d commands started, %0d finished,",
             sb.n_ticks, sb.n_checked, sb.n_started, sb.n_finished);
    $display("%0d dropped while busy; delays 0 to 100 under four idling profiles.",
             sb.n_dropped);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
